// ===== rtl/i2cmbe_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the i2c master byte engine
// no dependencies
package i2cmbe_pkg;

  localparam int unsigned DELAY_WIDTH_DEF = 16;
  localparam int unsigned HALF_PERIOD_W   = 16;
  localparam int unsigned TIMEOUT_W       = 8;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned CFG_IDX_W       = 1;

  localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 16'd10;
  localparam logic [TIMEOUT_W-1:0]     ACK_TIMEOUT_RST = 8'd250;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;

  // command codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_WACK  = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack;
  } out_item_t;

endpackage

// ===== rtl/i2c_master_byte_engine_core.sv =====
`timescale 1ns / 1ps
// i2c master byte engine top level: pin sequencer plus output register
// depends on i2cmbe_pkg
//
// Each input transfer is one tick of an I2C master pin sequencer; each
// tick yields exactly one result transfer with the SCL/SDA levels, the SDA
// drive enable, busy/done status, the last read byte and the nack flag.
// The block takes one transfer every clock cycle unless the result side
// stalls: the whole tick is one pass of next-state logic from the
// sequencer registers and the incoming transfer into the sequencer
// registers and the result register. The result register sits between the
// two sides, so a new input transfer is taken while a finished result is
// still waiting, as long as the result is taken in the same cycle
// (in_ready = result register empty or being drained). A command (start,
// stop, write byte, wait for ack, read byte) is only picked up when the
// sequencer is idle; commands arriving while busy are dropped. Half-period
// waits count half_period_ticks ticks (zero acts like one), cut to
// DELAY_WIDTH bits. Configuration writes via cfg_we/cfg_index/cfg_wdata
// take effect at once and should be made while the sequencer is idle.
module i2c_master_byte_engine_core
  import i2cmbe_pkg::*;
#(
  parameter int unsigned DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START1,
    PH_START2,
    PH_STOP0,
    PH_STOP1,
    PH_FINISH,
    PH_WB_DATA,
    PH_WB_HIGH,
    PH_WB_LOW,
    PH_WA_SCL,
    PH_WA_POLL,
    PH_RB_LOW,
    PH_RB_HIGH,
    PH_AK_HIGH,
    PH_AK_LOW,
    PH_AK_DRIVE
  } phase_t;

  // configuration
  logic [HALF_PERIOD_W-1:0] half_period_r;
  logic [TIMEOUT_W-1:0]     ack_timeout_r;

  // sequencer state
  phase_t                 phase_r, phase_nxt;
  logic [3:0]             bit_cnt_r, bit_cnt_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [DELAY_WIDTH-1:0] delay_r, delay_nxt;
  logic [TIMEOUT_W-1:0]   poll_r, poll_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic                   sda_en_r, sda_en_nxt;
  logic                   ack_choice_r, ack_choice_nxt;
  logic                   nack_r, nack_nxt;
  logic [7:0]             rx_hold_r, rx_hold_nxt;
  logic                   done_nxt;

  // result register
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  logic in_xfer;

  // half period reload value, cut or zero-extended to the counter width
  logic [HALF_PERIOD_W+DELAY_WIDTH-1:0] hp_ext;
  logic [DELAY_WIDTH-1:0]               hp;
  logic [DELAY_WIDTH-1:0]               arm_val;
  logic [3:0]                           bit_inc;

  assign hp_ext  = {{DELAY_WIDTH{1'b0}}, half_period_r};
  assign hp      = hp_ext[DELAY_WIDTH-1:0];
  // zero behaves like one: no extra wait ticks
  assign arm_val = (hp == '0) ? '0 : hp - 1'b1;
  assign bit_inc = bit_cnt_r + 4'd1;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one sequencer tick
  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    delay_nxt      = delay_r;
    poll_nxt       = poll_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    sda_en_nxt     = sda_en_r;
    ack_choice_nxt = ack_choice_r;
    nack_nxt       = nack_r;
    rx_hold_nxt    = rx_hold_r;
    done_nxt       = 1'b0;

    if (phase_r == PH_IDLE) begin
      // command decode, only while idle
      case (in_data.operation)
        OP_START: begin
          sda_en_nxt = 1'b1;
          sda_nxt    = 1'b1;
          scl_nxt    = 1'b1;
          delay_nxt  = arm_val;
          phase_nxt  = PH_START1;
        end
        OP_STOP: begin
          sda_en_nxt = 1'b1;
          scl_nxt    = 1'b0;
          sda_nxt    = 1'b0;
          delay_nxt  = arm_val;
          phase_nxt  = PH_STOP1;
        end
        OP_WRITE: begin
          sda_en_nxt  = 1'b1;
          scl_nxt     = 1'b0;
          sda_nxt     = in_data.tx_byte[7];
          shift_nxt   = {in_data.tx_byte[6:0], 1'b0};
          bit_cnt_nxt = 4'd0;
          delay_nxt   = arm_val;
          phase_nxt   = PH_WB_HIGH;
        end
        OP_WACK: begin
          nack_nxt   = 1'b0;
          sda_en_nxt = 1'b0;
          sda_nxt    = 1'b1;
          delay_nxt  = arm_val;
          phase_nxt  = PH_WA_SCL;
        end
        OP_READ: begin
          sda_en_nxt     = 1'b0;
          scl_nxt        = 1'b0;
          ack_choice_nxt = in_data.send_ack;
          shift_nxt      = 8'd0;
          bit_cnt_nxt    = 4'd0;
          delay_nxt      = arm_val;
          phase_nxt      = PH_RB_HIGH;
        end
        default: begin
          // no command, or an unused code
        end
      endcase
    end else if (delay_r != '0) begin
      // half period wait
      delay_nxt = delay_r - 1'b1;
    end else begin
      case (phase_r)
        PH_START1: begin
          sda_nxt   = 1'b0;
          delay_nxt = arm_val;
          phase_nxt = PH_START2;
        end
        PH_START2: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
        PH_STOP0: begin
          // stop after an ack timeout
          sda_en_nxt = 1'b1;
          scl_nxt    = 1'b0;
          sda_nxt    = 1'b0;
          delay_nxt  = arm_val;
          phase_nxt  = PH_STOP1;
        end
        PH_STOP1: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          delay_nxt = arm_val;
          phase_nxt = PH_FINISH;
        end
        PH_FINISH: begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
        PH_WB_DATA: begin
          sda_nxt   = shift_r[7];
          shift_nxt = {shift_r[6:0], 1'b0};
          delay_nxt = arm_val;
          phase_nxt = PH_WB_HIGH;
        end
        PH_WB_HIGH: begin
          scl_nxt   = 1'b1;
          delay_nxt = arm_val;
          phase_nxt = PH_WB_LOW;
        end
        PH_WB_LOW: begin
          scl_nxt     = 1'b0;
          delay_nxt   = arm_val;
          bit_cnt_nxt = bit_inc;
          phase_nxt   = bit_inc[3] ? PH_FINISH : PH_WB_DATA;
        end
        PH_WA_SCL: begin
          scl_nxt   = 1'b1;
          poll_nxt  = '0;
          delay_nxt = arm_val;
          phase_nxt = PH_WA_POLL;
        end
        PH_WA_POLL: begin
          if (!in_data.sda_in) begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end else if (poll_r >= ack_timeout_r) begin
            // give up: flag and release the bus with a stop
            nack_nxt  = 1'b1;
            phase_nxt = PH_STOP0;
          end else begin
            poll_nxt = poll_r + 1'b1;
          end
        end
        PH_RB_LOW: begin
          scl_nxt   = 1'b0;
          delay_nxt = arm_val;
          phase_nxt = PH_RB_HIGH;
        end
        PH_RB_HIGH: begin
          // sample on the same tick scl rises
          scl_nxt     = 1'b1;
          shift_nxt   = {shift_r[6:0], in_data.sda_in};
          bit_cnt_nxt = bit_inc;
          delay_nxt   = arm_val;
          phase_nxt   = bit_inc[3] ? PH_AK_DRIVE : PH_RB_LOW;
        end
        PH_AK_DRIVE: begin
          scl_nxt    = 1'b0;
          sda_en_nxt = 1'b1;
          sda_nxt    = !ack_choice_r;
          delay_nxt  = arm_val;
          phase_nxt  = PH_AK_HIGH;
        end
        PH_AK_HIGH: begin
          scl_nxt   = 1'b1;
          delay_nxt = arm_val;
          phase_nxt = PH_AK_LOW;
        end
        PH_AK_LOW: begin
          scl_nxt     = 1'b0;
          rx_hold_nxt = shift_r;
          phase_nxt   = PH_IDLE;
          done_nxt    = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    out_data_nxt.scl_out   = scl_nxt;
    out_data_nxt.sda_out   = sda_nxt;
    out_data_nxt.sda_drive = sda_en_nxt;
    out_data_nxt.busy_res  = (phase_nxt != PH_IDLE);
    out_data_nxt.done_res  = done_nxt;
    out_data_nxt.read_data = rx_hold_nxt;
    out_data_nxt.nack      = nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
      phase_r       <= PH_IDLE;
      bit_cnt_r     <= 4'd0;
      shift_r       <= 8'd0;
      delay_r       <= '0;
      poll_r        <= '0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      sda_en_r      <= 1'b1;
      ack_choice_r  <= 1'b0;
      nack_r        <= 1'b0;
      rx_hold_r     <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      // configuration writes, unknown indexes dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_HALF_PERIOD: half_period_r <= cfg_wdata[HALF_PERIOD_W-1:0];
          CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
          default: begin
          end
        endcase
      end

      if (in_xfer) begin
        phase_r      <= phase_nxt;
        bit_cnt_r    <= bit_cnt_nxt;
        shift_r      <= shift_nxt;
        delay_r      <= delay_nxt;
        poll_r       <= poll_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        sda_en_r     <= sda_en_nxt;
        ack_choice_r <= ack_choice_nxt;
        nack_r       <= nack_nxt;
        rx_hold_r    <= rx_hold_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== rtl/i2cmbe_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the i2c master byte engine, bound to the top level
// depends on i2cmbe_pkg and i2c_master_byte_engine_core
module i2cmbe_checker
  import i2cmbe_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // nothing pending right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // a finishing tick reports the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while busy");

  // results only follow an accepted input
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) |=> !out_valid)
    else $error("result without input transfer");

endmodule

bind i2c_master_byte_engine_core i2cmbe_checker u_i2cmbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for i2c_master_byte_engine_core: drives pin-sequencer ticks,
// predicts every result tick and compares it field by field
// depends on i2cmbe_pkg and i2c_master_byte_engine_core
module testbench;
  import i2cmbe_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_TICKS = 900;
  localparam int unsigned LONG_HOLD    = 40;

  // sequencer phases, same stepping as the block's control flow
  typedef enum logic [4:0] {
    SQ_IDLE, SQ_START1, SQ_START2, SQ_STOP0, SQ_STOP1, SQ_FINISH,
    SQ_WB_DATA, SQ_WB_HIGH, SQ_WB_LOW, SQ_WA_SCL, SQ_WA_POLL,
    SQ_RB_LOW, SQ_RB_HIGH, SQ_AK_HIGH, SQ_AK_LOW, SQ_AK_DRIVE
  } seq_phase_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  i2c_master_byte_engine_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // pin sequencer prediction: own copy of state and settings
  // ---------------------------------------------------------------------------
  seq_phase_e            sq_phase;
  logic [3:0]            sq_bits;
  logic [7:0]            sq_shift;
  logic [15:0]           sq_delay;
  logic [7:0]            sq_polls;
  logic                  sq_scl;
  logic                  sq_sda;
  logic                  sq_drive;
  logic                  sq_ack_sel;
  logic                  sq_nack;
  logic [7:0]            sq_rx_byte;
  logic [HALF_PERIOD_W-1:0] set_half_ticks;
  logic [TIMEOUT_W-1:0]     set_poll_limit;

  function automatic void reset_pin_sequencer();
    sq_phase       = SQ_IDLE;
    sq_bits        = '0;
    sq_shift       = '0;
    sq_delay       = '0;
    sq_polls       = '0;
    sq_scl         = 1'b1;
    sq_sda         = 1'b1;
    sq_drive       = 1'b1;
    sq_ack_sel     = 1'b0;
    sq_nack        = 1'b0;
    sq_rx_byte     = '0;
    set_half_ticks = HALF_PERIOD_RST;
    set_poll_limit = ACK_TIMEOUT_RST;
  endfunction

  // a half period of zero behaves like one: no extra wait ticks
  function automatic void arm_half_period();
    sq_delay = (set_half_ticks == '0) ? '0 : set_half_ticks - 16'd1;
  endfunction

  // one tick of the sequencer; returns the pin levels and status after it
  function automatic out_item_t step_pins(input in_item_t it);
    out_item_t r;
    logic      fin;
    fin = 1'b0;
    if (sq_phase == SQ_IDLE) begin
      case (it.operation)
        OP_START: begin
          sq_drive = 1'b1; sq_sda = 1'b1; sq_scl = 1'b1;
          arm_half_period(); sq_phase = SQ_START1;
        end
        OP_STOP: begin
          sq_drive = 1'b1; sq_scl = 1'b0; sq_sda = 1'b0;
          arm_half_period(); sq_phase = SQ_STOP1;
        end
        OP_WRITE: begin
          sq_drive = 1'b1; sq_scl = 1'b0; sq_sda = it.tx_byte[7];
          sq_shift = {it.tx_byte[6:0], 1'b0};
          sq_bits  = '0;
          arm_half_period(); sq_phase = SQ_WB_HIGH;
        end
        OP_WACK: begin
          sq_nack = 1'b0; sq_drive = 1'b0; sq_sda = 1'b1;
          arm_half_period(); sq_phase = SQ_WA_SCL;
        end
        OP_READ: begin
          sq_drive = 1'b0; sq_scl = 1'b0; sq_ack_sel = it.send_ack;
          sq_shift = '0; sq_bits = '0;
          arm_half_period(); sq_phase = SQ_RB_HIGH;
        end
        default: ;
      endcase
    end else if (sq_delay != '0) begin
      sq_delay = sq_delay - 16'd1;
    end else begin
      case (sq_phase)
        SQ_START1: begin
          sq_sda = 1'b0; arm_half_period(); sq_phase = SQ_START2;
        end
        SQ_START2: begin
          sq_scl = 1'b0; sq_phase = SQ_IDLE; fin = 1'b1;
        end
        SQ_STOP0: begin
          sq_drive = 1'b1; sq_scl = 1'b0; sq_sda = 1'b0;
          arm_half_period(); sq_phase = SQ_STOP1;
        end
        SQ_STOP1: begin
          sq_scl = 1'b1; sq_sda = 1'b1; arm_half_period(); sq_phase = SQ_FINISH;
        end
        SQ_FINISH: begin
          sq_phase = SQ_IDLE; fin = 1'b1;
        end
        SQ_WB_DATA: begin
          sq_sda   = sq_shift[7];
          sq_shift = {sq_shift[6:0], 1'b0};
          arm_half_period(); sq_phase = SQ_WB_HIGH;
        end
        SQ_WB_HIGH: begin
          sq_scl = 1'b1; arm_half_period(); sq_phase = SQ_WB_LOW;
        end
        SQ_WB_LOW: begin
          sq_scl = 1'b0; arm_half_period();
          sq_bits  = sq_bits + 4'd1;
          sq_phase = (sq_bits >= 4'd8) ? SQ_FINISH : SQ_WB_DATA;
        end
        SQ_WA_SCL: begin
          sq_scl = 1'b1; sq_polls = '0; arm_half_period(); sq_phase = SQ_WA_POLL;
        end
        SQ_WA_POLL: begin
          if (!it.sda_in) begin
            sq_scl = 1'b0; sq_phase = SQ_IDLE; fin = 1'b1;
          end else if (sq_polls >= set_poll_limit) begin
            // gave up waiting: flag it and run the stop sequence
            sq_nack = 1'b1; sq_phase = SQ_STOP0;
          end else begin
            sq_polls = sq_polls + 8'd1;
          end
        end
        SQ_RB_LOW: begin
          sq_scl = 1'b0; arm_half_period(); sq_phase = SQ_RB_HIGH;
        end
        SQ_RB_HIGH: begin
          sq_scl   = 1'b1;
          sq_shift = {sq_shift[6:0], it.sda_in};
          sq_bits  = sq_bits + 4'd1;
          arm_half_period();
          sq_phase = (sq_bits >= 4'd8) ? SQ_AK_DRIVE : SQ_RB_LOW;
        end
        SQ_AK_DRIVE: begin
          sq_scl = 1'b0; sq_drive = 1'b1; sq_sda = ~sq_ack_sel;
          arm_half_period(); sq_phase = SQ_AK_HIGH;
        end
        SQ_AK_HIGH: begin
          sq_scl = 1'b1; arm_half_period(); sq_phase = SQ_AK_LOW;
        end
        SQ_AK_LOW: begin
          sq_scl = 1'b0; sq_rx_byte = sq_shift; sq_phase = SQ_IDLE; fin = 1'b1;
        end
        default: sq_phase = SQ_IDLE;
      endcase
    end
    r.scl_out   = sq_scl;
    r.sda_out   = sq_sda;
    r.sda_drive = sq_drive;
    r.busy_res  = (sq_phase != SQ_IDLE);
    r.done_res  = fin;
    r.read_data = sq_rx_byte;
    r.nack      = sq_nack;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // shared bookkeeping
  // ---------------------------------------------------------------------------
  out_item_t pending_pins[$];
  out_item_t want_pins;
  int        mismatches;
  int        ticks_sent;
  int        results_seen;
  int        cmd_seen [8];
  int        ack_timeouts;
  int        half_settings;
  int        idle_cycles;
  bit        tx_gaps;
  bit        rx_stalls;
  int        rx_hold_req;

  // ---------------------------------------------------------------------------
  // result side: ready pattern and checker
  // ---------------------------------------------------------------------------
  // one assignment to out_ready per clock step; a long hold is requested by
  // the stimulus through rx_hold_req and counted out here
  initial begin
    forever begin
      if (rx_hold_req != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_req) @(posedge clk);
        rx_hold_req = 0;
      end else if (rx_stalls && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic report_mismatch(input string why, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at result %0d (%s): expected scl=%b sda=%b drv=%b busy=%b done=%b rd=%02h nack=%b, got scl=%b sda=%b drv=%b busy=%b done=%b rd=%02h nack=%b",
               results_seen, why,
               want.scl_out, want.sda_out, want.sda_drive, want.busy_res, want.done_res,
               want.read_data, want.nack,
               got.scl_out, got.sda_out, got.sda_drive, got.busy_res, got.done_res,
               got.read_data, got.nack);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_pins.size() == 0) begin
        report_mismatch("no result expected", '0, out_data);
      end else begin
        want_pins = pending_pins.pop_front();
        if (out_data.scl_out !== want_pins.scl_out ||
            out_data.sda_out !== want_pins.sda_out ||
            out_data.sda_drive !== want_pins.sda_drive ||
            out_data.busy_res !== want_pins.busy_res ||
            out_data.done_res !== want_pins.done_res ||
            out_data.read_data !== want_pins.read_data ||
            out_data.nack !== want_pins.nack)
          report_mismatch("field differs", want_pins, out_data);
      end
    end
  end

  // watchdog: counts cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_pins.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  function automatic logic pick_sda(input int low_pct);
    return (int'($urandom_range(0, 99)) < low_pct) ? 1'b0 : 1'b1;
  endfunction

  // one tick transfer; valid is only lowered when a gap is taken, so a
  // back-to-back transfer never sees a low/high pair in one step
  task automatic send_tick(input in_item_t it);
    logic nack_before;
    if (tx_gaps && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (sq_phase == SQ_IDLE)
      cmd_seen[it.operation]++;
    nack_before = sq_nack;
    pending_pins.push_back(step_pins(it));
    if (!nack_before && sq_nack)
      ack_timeouts++;
    ticks_sent++;
  endtask

  // issues a command and keeps ticking until the sequencer is idle again;
  // filler ticks carry random commands that must be dropped while busy
  task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                         input int low_pct);
    in_item_t it;
    it.operation = op;
    it.tx_byte   = tx;
    it.send_ack  = ack;
    it.sda_in    = pick_sda(low_pct);
    send_tick(it);
    while (sq_phase != SQ_IDLE) begin
      it.operation = ($urandom_range(0, 1) == 0) ? OP_NONE : 3'($urandom_range(0, 7));
      it.tx_byte   = 8'($urandom);
      it.send_ack  = 1'($urandom);
      it.sda_in    = pick_sda(low_pct);
      send_tick(it);
    end
  endtask

  // sender pause until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HALF_PERIOD) begin
      set_half_ticks = val;
      half_settings++;
    end else begin
      set_poll_limit = val[TIMEOUT_W-1:0];
    end
  endtask

  // well-formed bus transaction with random content
  task automatic bus_transaction();
    int n_data;
    n_data = $urandom_range(1, 3);
    run_cmd(OP_START, 8'($urandom), 1'($urandom), 50);
    run_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 50);
    case ($urandom_range(0, 3))
      0:       run_cmd(OP_WACK, 8'($urandom), 1'($urandom), 0);
      1:       run_cmd(OP_WACK, 8'($urandom), 1'($urandom), 30);
      default: run_cmd(OP_WACK, 8'($urandom), 1'($urandom), 100);
    endcase
    repeat (n_data) begin
      if ($urandom_range(0, 1) == 0) begin
        run_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 50);
        run_cmd(OP_WACK, 8'($urandom), 1'($urandom), 60);
      end else begin
        run_cmd(OP_READ, 8'($urandom), 1'($urandom), 50);
      end
    end
    run_cmd(OP_STOP, 8'($urandom), 1'($urandom), 50);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_each_command();
    // no-op codes at idle, then a start at the reset half period
    run_cmd(OP_NONE, 8'hFF, 1'b1, 0);
    run_cmd(3'd6, 8'h00, 1'b0, 100);
    run_cmd(3'd7, 8'h5A, 1'b1, 50);
    run_cmd(OP_START, 8'h00, 1'b0, 50);
    write_reg(CFG_HALF_PERIOD, 16'd1);
    write_reg(CFG_ACK_TIMEOUT, 16'd3);
    run_cmd(OP_WRITE, 8'h00, 1'b0, 50);
    run_cmd(OP_WRITE, 8'hFF, 1'b1, 50);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, 50);
    run_cmd(OP_WACK, 8'h00, 1'b0, 100);
    // ack never comes: timeout, stop sequence and nack
    run_cmd(OP_WACK, 8'h00, 1'b0, 0);
    run_cmd(OP_WACK, 8'h00, 1'b0, 100);
    run_cmd(OP_READ, 8'h00, 1'b1, 0);
    run_cmd(OP_READ, 8'hFF, 1'b0, 100);
    run_cmd(OP_READ, 8'h3C, 1'b1, 50);
    run_cmd(OP_STOP, 8'h00, 1'b0, 50);
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_HALF_PERIOD, 16'd0);
    run_cmd(OP_START, 8'h00, 1'b0, 50);
    run_cmd(OP_WRITE, 8'($urandom), 1'b0, 50);
    run_cmd(OP_READ, 8'h00, 1'b0, 50);
    // zero timeout gives up on the first high poll
    write_reg(CFG_ACK_TIMEOUT, 16'd0);
    run_cmd(OP_WACK, 8'h00, 1'b0, 0);
    write_reg(CFG_HALF_PERIOD, 16'd1);
    write_reg(CFG_ACK_TIMEOUT, 16'hFFFF);
    run_cmd(OP_WACK, 8'h00, 1'b0, 0);
    // long half period: one stop, run without gaps to keep it short
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    write_reg(CFG_HALF_PERIOD, 16'd100);
    run_cmd(OP_STOP, 8'h00, 1'b0, 50);
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
  endtask

  task automatic test_output_hold();
    write_reg(CFG_HALF_PERIOD, 16'd2);
    write_reg(CFG_ACK_TIMEOUT, 16'd4);
    // receiver holds off while the sender keeps offering ticks
    rx_hold_req = LONG_HOLD;
    run_cmd(OP_WRITE, 8'($urandom), 1'b0, 50);
    rx_hold_req = LONG_HOLD;
    run_cmd(OP_READ, 8'($urandom), 1'b1, 50);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int start_ticks;
    start_ticks = ticks_sent;
    while (ticks_sent - start_ticks < RANDOM_TICKS) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 4) == 0)
          write_reg(CFG_HALF_PERIOD, 16'($urandom_range(4, 12)));
        else
          write_reg(CFG_HALF_PERIOD, 16'($urandom_range(0, 3)));
        if ($urandom_range(0, 4) == 0)
          write_reg(CFG_ACK_TIMEOUT, {8'($urandom), 8'($urandom_range(250, 255))});
        else
          write_reg(CFG_ACK_TIMEOUT, {8'($urandom), 8'($urandom_range(0, 6))});
      end
      if ($urandom_range(0, 4) == 0)
        run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 50);
      else
        bus_transaction();
    end
  endtask

  task automatic test_steady_tail();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    write_reg(CFG_HALF_PERIOD, 16'd1);
    write_reg(CFG_ACK_TIMEOUT, 16'd2);
    repeat (4) bus_transaction();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    mismatches    = 0;
    ticks_sent    = 0;
    results_seen  = 0;
    ack_timeouts  = 0;
    half_settings = 0;
    idle_cycles   = 0;
    rx_hold_req   = 0;
    tx_gaps       = 1'b1;
    rx_stalls     = 1'b1;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    reset_pin_sequencer();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_each_command();
    test_register_extremes();
    test_output_hold();
    test_random_traffic();
    test_steady_tail();

    drain_results();
    repeat (5) @(posedge clk);
    $display("covered %0d ticks / %0d results: %0d starts, %0d stops, %0d writes, %0d reads",
             ticks_sent, results_seen, cmd_seen[OP_START], cmd_seen[OP_STOP],
             cmd_seen[OP_WRITE], cmd_seen[OP_READ]);
    $display("%0d ack waits (%0d timed out), %0d half-period settings, long output holds",
             cmd_seen[OP_WACK], ack_timeouts, half_settings);
    if (mismatches == 0 && pending_pins.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
